// ===== rtl/core/pvd_pkg.sv =====
// ----------------------------------------------------------------------------
// pvd_pkg
// Shared types and constants of the peak and valley detector.
// ----------------------------------------------------------------------------
`default_nettype none

package pvd_pkg;

  localparam int unsigned SAMPLE_BITS = 24;
  localparam int unsigned MAX_LEN     = 65536;
  localparam int unsigned IDX_W       = $clog2(MAX_LEN);
  localparam int unsigned POS_W       = 16;
  localparam logic [IDX_W-1:0] IDX_MAX = IDX_W'(MAX_LEN - 1);

  // Results one input sample can cause, and the depth of the result queue.
  localparam int unsigned MAX_RESULTS = 3;
  localparam int unsigned RES_CNT_W   = $clog2(MAX_RESULTS + 1);
  localparam int unsigned RES_IDX_W   = $clog2(MAX_RESULTS);
  localparam int unsigned QDEPTH      = 4;
  localparam int unsigned QCNT_W      = $clog2(QDEPTH + 1);
  localparam int unsigned QIDX_W      = $clog2(QDEPTH);

  localparam logic [1:0] PEAKS_SAT = 2'd2;

  typedef enum logic [1:0] {
    KIND_PEAK      = 2'd0,
    KIND_VALLEY    = 2'd1,
    KIND_SHORT     = 2'd2,
    KIND_FEW_PEAKS = 2'd3
  } kind_e;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;

  typedef struct packed {
    kind_e            kind;
    logic [POS_W-1:0] position;
    sample_t          level;
    logic             end_of_run;
  } result_t;

  function automatic result_t make_result(kind_e kind, logic [POS_W-1:0] position,
                                          sample_t level);
    result_t r;
    r.kind       = kind;
    r.position   = position;
    r.level      = level;
    r.end_of_run = 1'b0;
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/pvd_track.sv =====
// ----------------------------------------------------------------------------
// pvd_track
// Holds the record state and forms the results of one accepted sample.
// ----------------------------------------------------------------------------
`default_nettype none

module pvd_track (
  input  wire logic                                       clk_i,
  input  wire logic                                       rst_ni,
  input  wire logic                                       accept_i,
  input  wire pvd_pkg::sample_t                           sample_i,
  input  wire logic                                       last_sample_i,
  output pvd_pkg::result_t [pvd_pkg::MAX_RESULTS-1:0]     res_o,
  output logic [pvd_pkg::RES_CNT_W-1:0]                   num_o
);
  import pvd_pkg::*;

  sample_t          prior_q, prior_d;
  sample_t          older_q, older_d;
  logic [IDX_W-1:0] idx_q, idx_d;
  logic [1:0]       peaks_q, peaks_d;
  sample_t          rmin_q, rmin_d;
  logic [IDX_W-1:0] rmin_idx_q, rmin_idx_d;

  logic                                 peak;
  logic [IDX_W-1:0]                     prev_idx;
  sample_t                              fin_min;
  logic [IDX_W-1:0]                     fin_idx;
  result_t [MAX_RESULTS-1:0]            res;
  logic [RES_CNT_W-1:0]                 k;

  always_comb begin
    peak       = (idx_q >= IDX_W'(2)) && (prior_q > older_q) && (prior_q > sample_i);
    prev_idx   = idx_q - IDX_W'(1);
    prior_d    = prior_q;
    older_d    = older_q;
    idx_d      = idx_q;
    peaks_d    = peaks_q;
    rmin_d     = rmin_q;
    rmin_idx_d = rmin_idx_q;
    fin_min    = rmin_q;
    fin_idx    = rmin_idx_q;
    res        = '0;
    k          = '0;

    if (peak) begin
      // The valley between two peaks goes out just before the newer peak.
      if (peaks_q != 2'd0) begin
        res[k[RES_IDX_W-1:0]] = make_result(KIND_VALLEY, POS_W'(rmin_idx_q), rmin_q);
        k = k + RES_CNT_W'(1);
      end
      res[k[RES_IDX_W-1:0]] = make_result(KIND_PEAK, POS_W'(prev_idx), prior_q);
      k          = k + RES_CNT_W'(1);
      rmin_d     = prior_q;
      rmin_idx_d = prev_idx;
      peaks_d    = (peaks_q == PEAKS_SAT) ? PEAKS_SAT : peaks_q + 2'd1;
    end else if ((peaks_q != 2'd0) && (idx_q != '0) && (prior_q < rmin_q)) begin
      rmin_d     = prior_q;
      rmin_idx_d = prev_idx;
    end

    if (last_sample_i) begin
      if (idx_q == '0) begin
        res[k[RES_IDX_W-1:0]] = make_result(KIND_SHORT, '0, '0);
      end else if (peaks_d < PEAKS_SAT) begin
        res[k[RES_IDX_W-1:0]] = make_result(KIND_FEW_PEAKS, '0, '0);
      end else begin
        fin_min = rmin_d;
        fin_idx = rmin_idx_d;
        if (sample_i < rmin_d) begin
          fin_min = sample_i;
          fin_idx = idx_q;
        end
        res[k[RES_IDX_W-1:0]] = make_result(KIND_VALLEY, POS_W'(fin_idx), fin_min);
      end
      k          = k + RES_CNT_W'(1);
      prior_d    = '0;
      older_d    = '0;
      idx_d      = '0;
      peaks_d    = '0;
      rmin_d     = '0;
      rmin_idx_d = '0;
    end else begin
      older_d = prior_q;
      prior_d = sample_i;
      if (idx_q != IDX_MAX) begin
        idx_d = idx_q + IDX_W'(1);
      end
    end

    if (k != '0) begin
      res[RES_IDX_W'(k - RES_CNT_W'(1))].end_of_run = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prior_q    <= '0;
      older_q    <= '0;
      idx_q      <= '0;
      peaks_q    <= '0;
      rmin_q     <= '0;
      rmin_idx_q <= '0;
    end else if (accept_i) begin
      prior_q    <= prior_d;
      older_q    <= older_d;
      idx_q      <= idx_d;
      peaks_q    <= peaks_d;
      rmin_q     <= rmin_d;
      rmin_idx_q <= rmin_idx_d;
    end
  end

  assign res_o = res;
  assign num_o = k;

  a_peaks_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    peaks_q != 2'd3)
    else $error("peak count passed saturation");

  a_record_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && last_sample_i |=> (idx_q == '0) && (peaks_q == 2'd0))
    else $error("record state not cleared after last sample");

  a_index_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && !last_sample_i && (idx_q != IDX_MAX) |=> idx_q == $past(idx_q) + IDX_W'(1))
    else $error("sample index did not advance");

  a_final_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && last_sample_i |-> num_o != '0)
    else $error("last sample produced no result");

endmodule

`default_nettype wire

// ===== rtl/core/peak_valley_detector_core.sv =====
// ----------------------------------------------------------------------------
// peak_valley_detector_core
// Finds peaks and valleys in a record of weight samples and flags records that are
// too short or have too few peaks; results in order.
// A sample's results enter the result queue in the cycle after the sample is taken.
// Throughput: one sample per cycle while each sample yields at most one result and
// the receiver takes every result; a sample yielding two or three results holds the
// input until the queue drains, since a sample is only taken while at most one result waits in the queue.
// Reset: asynchronous, active low; clears the record state and empties the queue.
`default_nettype none

module peak_valley_detector_core (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire pvd_pkg::sample_t              sample_i,
  input  wire logic                          last_sample_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic [1:0]                         kind_o,
  output logic [pvd_pkg::POS_W-1:0]          position_o,
  output pvd_pkg::sample_t                   level_o,
  output logic                               end_of_run_o
);
  import pvd_pkg::*;

  logic                       accept;
  logic                       pop;
  result_t [MAX_RESULTS-1:0]  res;
  logic [RES_CNT_W-1:0]       num;
  logic [RES_CNT_W-1:0]       push_n;
  logic [QCNT_W-1:0]          cnt_after;
  logic [QCNT_W-1:0]          offs;
  logic [QIDX_W-1:0]          tail_idx;

  result_t           q_q [QDEPTH];
  result_t           q_d [QDEPTH];
  logic [QCNT_W-1:0] count_q, count_d;

  assign in_ready_o = (count_q <= QCNT_W'(1));
  assign accept     = in_valid_i && in_ready_o;
  assign out_valid_o = (count_q != '0);
  assign pop        = out_valid_o && out_ready_i;

  pvd_track u_track (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .sample_i      (sample_i),
    .last_sample_i (last_sample_i),
    .res_o         (res),
    .num_o         (num)
  );

  // Shift queue: the head is always entry 0, new results append behind the tail.
  always_comb begin
    push_n    = accept ? num : '0;
    cnt_after = count_q - QCNT_W'(pop);
    offs      = '0;
    for (int i = 0; i < QDEPTH; i++) begin
      if (pop && (i < QDEPTH - 1)) begin
        q_d[i] = q_q[(i < QDEPTH - 1) ? i + 1 : i];
      end else begin
        q_d[i] = q_q[i];
      end
      offs = QCNT_W'(i) - cnt_after;
      if ((QCNT_W'(i) >= cnt_after) && (offs < QCNT_W'(push_n))) begin
        q_d[i] = res[offs[RES_IDX_W-1:0]];
      end
    end
    count_d = cnt_after + QCNT_W'(push_n);
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < QDEPTH; i++) begin
      q_q[i] <= q_d[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  assign kind_o       = q_q[0].kind;
  assign position_o   = q_q[0].position;
  assign level_o      = q_q[0].level;
  assign end_of_run_o = q_q[0].end_of_run;

  assign tail_idx = QIDX_W'(count_q - QCNT_W'(1));

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= QCNT_W'(QDEPTH))
    else $error("result queue overflow");

  a_count_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> count_q == $past(count_q) + QCNT_W'($past(push_n)) - QCNT_W'($past(pop)))
    else $error("result queue count out of step");

  a_tail_closes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q != '0 |-> q_q[tail_idx].end_of_run)
    else $error("queue tail does not close a sample's results");

endmodule

`default_nettype wire

// ===== sim/peak_valley_detector_core_tb.sv =====
// ----------------------------------------------------------------------------
// peak_valley_detector_core_tb
// Streams weight records through the detector and compares every peak,
// valley and error result, in stream order, with an in-bench prediction.
// Sender gaps and receiver stalls vary by phase, and one long receiver
// hold-off backs up the result queue.
// ----------------------------------------------------------------------------

module peak_valley_detector_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import pvd_pkg::*;

  localparam int LEVEL_MIN      = -(2 ** (SAMPLE_BITS - 1));
  localparam int LEVEL_MAX      = 2 ** (SAMPLE_BITS - 1) - 1;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int HOLD_OFF_LEN   = 300;
  localparam int ITEMS_PER_PHASE = 75;

  // Predicts the results of each accepted sample and holds them until the
  // matching transfer comes out of the block.
  class extrema_scoreboard;
    sample_t          prior_level;
    sample_t          older_level;
    sample_t          trough_level;
    logic [IDX_W-1:0] next_index;
    logic [IDX_W-1:0] trough_index;
    int unsigned      peak_count;
    result_t          expected_extrema[$];
    int unsigned      error_count;

    function new();
      error_count = 0;
      clear_record();
    endfunction

    function void clear_record();
      prior_level  = '0;
      older_level  = '0;
      trough_level = '0;
      next_index   = '0;
      trough_index = '0;
      peak_count   = 0;
    endfunction

    function int unsigned pending();
      return expected_extrema.size();
    endfunction

    function void note_sample(sample_t x, logic last);
      logic [IDX_W-1:0] n;
      logic [IDX_W-1:0] prev_pos;
      result_t          found[MAX_RESULTS];
      int unsigned      cnt;
      n        = next_index;
      prev_pos = (n > 0) ? n - 1'b1 : '0;
      cnt      = 0;

      if (n >= 2 && prior_level > older_level && prior_level > x) begin
        if (peak_count >= 1) begin
          found[cnt] = '{KIND_VALLEY, POS_W'(trough_index), trough_level, 1'b0};
          cnt++;
        end
        found[cnt] = '{KIND_PEAK, POS_W'(prev_pos), prior_level, 1'b0};
        cnt++;
        trough_level = prior_level;
        trough_index = prev_pos;
        if (peak_count < 2) peak_count++;
      end else if (peak_count >= 1 && n >= 1 && prior_level < trough_level) begin
        trough_level = prior_level;
        trough_index = prev_pos;
      end

      if (last) begin
        if (n == 0) begin
          found[cnt] = '{KIND_SHORT, '0, '0, 1'b0};
        end else if (peak_count < 2) begin
          found[cnt] = '{KIND_FEW_PEAKS, '0, '0, 1'b0};
        end else begin
          if (x < trough_level) begin
            trough_level = x;
            trough_index = n;
          end
          found[cnt] = '{KIND_VALLEY, POS_W'(trough_index), trough_level, 1'b0};
        end
        cnt++;
        clear_record();
      end else begin
        older_level = prior_level;
        prior_level = x;
        if (n != IDX_MAX) next_index = n + 1'b1;
      end

      if (cnt > 0) found[cnt-1].end_of_run = 1'b1;
      for (int i = 0; i < cnt; i++) begin
        expected_extrema.insert(expected_extrema.size(), found[i]);
      end
    endfunction

    function void check_result(logic [1:0] kind, logic [POS_W-1:0] position,
                               sample_t level, logic end_of_run);
      result_t want;
      if (expected_extrema.size() == 0) begin
        $error("unexpected result: kind %0d position %0d level %0d", kind, position,
               level);
        error_count++;
        return;
      end
      want = expected_extrema.pop_front();
      if (kind !== want.kind) begin
        $error("kind: expected %0d, actual %0d", want.kind, kind);
        error_count++;
      end
      if (position !== want.position) begin
        $error("position: expected %0d, actual %0d", want.position, position);
        error_count++;
      end
      if (level !== want.level) begin
        $error("level: expected %0d, actual %0d", want.level, level);
        error_count++;
      end
      if (end_of_run !== want.end_of_run) begin
        $error("end_of_run: expected %0d, actual %0d", want.end_of_run, end_of_run);
        error_count++;
      end
    endfunction
  endclass

  logic              clk_i         = 1'b0;
  logic              rst_n         = 1'b0;
  logic              in_valid      = 1'b0;
  logic              in_ready;
  sample_t           sample_r      = '0;
  logic              last_r        = 1'b0;
  logic              out_valid;
  logic              out_ready     = 1'b0;
  logic [1:0]        kind;
  logic [POS_W-1:0]  position;
  sample_t           level;
  logic              end_of_run;

  extrema_scoreboard sb = new();
  int unsigned       src_idle_pct  = 0;
  int unsigned       sink_stall_pct = 0;
  int                hold_left     = 0;
  int                idle_cycles   = 0;
  int                sent          = 0;

  peak_valley_detector_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_ready_o    (in_ready),
    .sample_i      (sample_r),
    .last_sample_i (last_r),
    .out_valid_o   (out_valid),
    .out_ready_i   (out_ready),
    .kind_o        (kind),
    .position_o    (position),
    .level_o       (level),
    .end_of_run_o  (end_of_run)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Receiver: a requested hold-off wins over the random stall pattern.
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else begin
        out_ready <= ($urandom_range(99) >= sink_stall_pct);
      end
    end
  end

  // Both channels are observed at the edge; values read here are pre-edge.
  always @(posedge clk_i) begin
    if (rst_n) begin
      if (out_valid && out_ready) sb.check_result(kind, position, level, end_of_run);
      if (in_valid && in_ready) sb.note_sample(sample_r, last_r);
      if ((out_valid && out_ready) || (in_valid && in_ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  task automatic send_sample(int value, logic last);
    if ($urandom_range(99) < src_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < src_idle_pct);
    end
    in_valid <= 1'b1;
    sample_r <= sample_t'(value);
    last_r   <= last;
    do @(posedge clk_i); while (!(in_valid && in_ready));
    sent++;
  endtask

  task automatic send_seq(int values[$]);
    foreach (values[i]) send_sample(values[i], i == values.size() - 1);
  endtask

  task automatic send_random_record();
    int len;
    int shape;
    int start;
    int step;
    int v;
    int pick;
    pick = $urandom_range(99);
    if (pick < 5) len = 1;
    else if (pick < 10) len = 2;
    else len = $urandom_range(18, 3);
    shape = $urandom_range(99);
    start = int'($urandom_range(1000)) - 500;
    step  = int'($urandom_range(3));
    if ($urandom_range(1)) step = -step;
    for (int i = 0; i < len; i++) begin
      if (shape < 40) begin
        v = int'($urandom_range(8)) - 4;
      end else if (shape < 75) begin
        v = int'(sample_t'($urandom));
      end else if (shape < 90) begin
        case ($urandom_range(3))
          0: v = LEVEL_MIN;
          1: v = LEVEL_MAX;
          2: v = -1;
          default: v = 0;
        endcase
      end else begin
        // Monotonic ramps cannot form two peaks.
        v = start + i * step;
      end
      send_sample(v, i == len - 1);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  initial begin
    int seq[$];
    repeat (12) @(posedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);

    // Directed records.
    send_sample(LEVEL_MAX, 1'b1);
    seq = '{LEVEL_MIN, LEVEL_MAX};
    send_seq(seq);
    seq = '{0, 5, 1, 7, 2};
    send_seq(seq);
    seq = '{LEVEL_MIN, LEVEL_MAX, LEVEL_MIN, LEVEL_MAX, LEVEL_MIN};
    send_seq(seq);
    seq = '{0, 1, 0};
    send_seq(seq);
    seq = '{3, 3, 3};
    send_seq(seq);
    seq = '{-1, 2, 2, -3, 4, -3, 1};
    send_seq(seq);
    drain();

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
        1: begin src_idle_pct = 73; sink_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  sink_stall_pct = 73; end
        default: begin src_idle_pct = 10; sink_stall_pct = 10; end
      endcase
      if (phase == 0) hold_left = HOLD_OFF_LEN;
      sent = 0;
      while (sent < ITEMS_PER_PHASE) send_random_record();
      drain();
    end

    repeat (20) @(posedge clk_i);
    if (sb.error_count == 0 && sb.pending() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
